FILE: rtl/assert_macros.svh
// assertion helpers for the rtl, clocked on the rising edge and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IDU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define IDU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/idu_pkg.sv
package idu_pkg;

   localparam int unsigned FuncWidth = 4;
   localparam int unsigned KindWidth = 2;
   localparam int unsigned BeatWidth = 3;

   typedef logic [FuncWidth-1:0] func_type;
   typedef logic [KindWidth-1:0] kind_type;
   typedef logic [BeatWidth-1:0] beat_type;

   // instruction codes
   localparam func_type FUNC_INX     = 4'd0;
   localparam func_type FUNC_INY     = 4'd1;
   localparam func_type FUNC_DEX     = 4'd2;
   localparam func_type FUNC_DEY     = 4'd3;
   localparam func_type FUNC_INC_ZP  = 4'd4;
   localparam func_type FUNC_INC_ZPX = 4'd5;
   localparam func_type FUNC_INC_ABS = 4'd6;
   localparam func_type FUNC_INC_ABX = 4'd7;
   localparam func_type FUNC_DEC_ZP  = 4'd8;
   localparam func_type FUNC_DEC_ZPX = 4'd9;
   localparam func_type FUNC_DEC_ABS = 4'd10;
   localparam func_type FUNC_DEC_ABX = 4'd11;
   localparam func_type FUNC_LOAD_PC = 4'd12;
   localparam func_type FUNC_LOAD_XY = 4'd13;

   // addressing modes of the memory forms
   localparam logic [1:0] MODE_ZP  = 2'd0;
   localparam logic [1:0] MODE_ZPX = 2'd1;
   localparam logic [1:0] MODE_ABS = 2'd2;
   localparam logic [1:0] MODE_ABX = 2'd3;

   // bus cycle kinds
   localparam kind_type KIND_READ  = 2'd0;
   localparam kind_type KIND_WRITE = 2'd1;
   localparam kind_type KIND_NONE  = 2'd2;

   localparam logic [7:0] BYTE_ONES = 8'hFF;

   // one instruction held while its beats go out
   typedef struct packed {
      func_type    func;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [7:0]  mem;
      logic [7:0]  new_value;
      logic [15:0] pc;
      logic [7:0]  x_old;
      logic [7:0]  new_x;
      logic [7:0]  new_y;
      logic        new_z;
      logic        new_n;
   } job_type;

endpackage

FILE: rtl/index_and_memory_inc_dec_unit.sv
// increment / decrement unit of a small 8-bit processor core
//
// req channel: one beat per instruction (func, operand bytes, the byte the
//   target address returns). func 14 and 15 are taken and dropped.
// rsp channel: one beat per bus cycle of the instruction, in bus order;
//   last_cycle marks the final beat. x, y, z and n on every beat are the
//   values after the instruction.
// a taken req beat is held in the job register; its beats then pass through
//   the output register. throughput: one rsp beat per cycle while rsp_ready
//   is high; an instruction has as many beats as bus cycles: 1 for register
//   forms and loads, 4 for zero page, 5 for zero page x and absolute, 6 for
//   absolute x. the single output register sets this rate.
// the next req beat is taken in the same cycle the last rsp beat of the
//   current instruction moves into the output register, so one-beat
//   instructions stream at one per cycle while rsp_ready stays high.
// stall: while rsp_ready is low the output register holds its beat, the beat
//   sequencer stops and req_ready drops once the held instruction is pending.
// reset: x, y, pc, z and n clear to zero, nothing is in flight.
module index_and_memory_inc_dec_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  idu_pkg::func_type      req_func,
   input  logic [7:0]             req_operand_low,
   input  logic [7:0]             req_operand_high,
   input  logic [7:0]             req_memory_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_bus_address,
   output logic [7:0]             rsp_bus_data,
   output idu_pkg::kind_type      rsp_bus_kind,
   output logic                   rsp_last_cycle,
   output logic                   rsp_zero_flag,
   output logic                   rsp_negative_flag,
   output logic [7:0]             rsp_index_x_out,
   output logic [7:0]             rsp_index_y_out
);
   import idu_pkg::*;

   `include "assert_macros.svh"

   // architectural state, updated when an instruction is taken
   logic [7:0]  index_x_ff, index_x_in;
   logic [7:0]  index_y_ff, index_y_in;
   logic [15:0] pc_ff, pc_in;
   logic        flag_z_ff, flag_z_in;
   logic        flag_n_ff, flag_n_in;

   // instruction being sequenced
   job_type     job_ff, job_in;
   logic        job_valid_ff, job_valid_in;
   beat_type    beat_ff, beat_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_z_ff, rsp_z_in;
   logic        rsp_n_ff, rsp_n_in;
   logic [7:0]  rsp_x_ff, rsp_x_in;
   logic [7:0]  rsp_y_ff, rsp_y_in;

   logic        req_take;
   logic        req_real;
   logic        issue;
   logic        issue_last;
   logic [7:0]  acc_new_value;

   // beat decode of the held instruction
   logic        job_rmw;
   logic [1:0]  job_mode;
   beat_type    prefix_beats;
   beat_type    total_beats;
   beat_type    rmw_step;
   logic [7:0]  zpx_low;
   logic [15:0] abx_addr;
   logic [15:0] eff_addr;
   logic [15:0] beat_addr;
   logic [7:0]  beat_data;
   kind_type    beat_kind;
   logic        beat_last;

   // ---------------------------------------------------------------------
   // beat sequencing
   // ---------------------------------------------------------------------
   assign job_mode   = job_ff.func[1:0];
   assign job_rmw    = (job_ff.func >= FUNC_INC_ZP) && (job_ff.func <= FUNC_DEC_ABX);

   always_comb begin
      case (job_mode)
         MODE_ZP:  prefix_beats = beat_type'(1);
         MODE_ZPX: prefix_beats = beat_type'(2);
         MODE_ABS: prefix_beats = beat_type'(2);
         default:  prefix_beats = beat_type'(3);
      endcase
   end

   // read, dummy write of the old value, write of the new value
   assign total_beats = job_rmw ? (prefix_beats + beat_type'(3)) : beat_type'(1);
   assign beat_last   = (beat_ff == (total_beats - beat_type'(1)));
   assign rmw_step    = beat_ff - prefix_beats;

   assign zpx_low  = job_ff.lo + job_ff.x_old;
   assign abx_addr = {job_ff.hi, job_ff.lo} + {8'h00, job_ff.x_old};

   always_comb begin
      case (job_mode)
         MODE_ZP:  eff_addr = {8'h00, job_ff.lo};
         MODE_ZPX: eff_addr = {8'h00, zpx_low};
         MODE_ABS: eff_addr = {job_ff.hi, job_ff.lo};
         default:  eff_addr = abx_addr;
      endcase
   end

   always_comb begin
      beat_addr = 16'h0000;
      beat_data = 8'h00;
      beat_kind = KIND_READ;
      if (!job_rmw) begin
         // register forms do a dummy read at pc, loads do no bus cycle
         if ((job_ff.func == FUNC_LOAD_PC) || (job_ff.func == FUNC_LOAD_XY)) begin
            beat_kind = KIND_NONE;
         end else begin
            beat_addr = job_ff.pc;
         end
      end else if (beat_ff < prefix_beats) begin
         case (beat_ff)
            beat_type'(0): begin
               beat_addr = job_ff.pc;
               beat_data = job_ff.lo;
            end
            beat_type'(1): begin
               if (job_mode == MODE_ZPX) begin
                  // dummy read of the unindexed zero page address
                  beat_addr = {8'h00, job_ff.lo};
               end else begin
                  beat_addr = job_ff.pc + 16'd1;
                  beat_data = job_ff.hi;
               end
            end
            default: begin
               // dummy read before the carry into the high byte
               beat_addr = {job_ff.hi, zpx_low};
            end
         endcase
      end else begin
         beat_addr = eff_addr;
         case (rmw_step)
            beat_type'(0): begin
               beat_data = job_ff.mem;
               beat_kind = KIND_READ;
            end
            beat_type'(1): begin
               beat_data = job_ff.mem;
               beat_kind = KIND_WRITE;
            end
            default: begin
               beat_data = job_ff.new_value;
               beat_kind = KIND_WRITE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   assign issue      = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue_last = issue && beat_last;
   assign req_ready  = !job_valid_ff || issue_last;
   assign req_take   = req_valid && req_ready;
   assign req_real   = req_take && (req_func <= FUNC_LOAD_XY);

   // ---------------------------------------------------------------------
   // execute at accept: new state and the held job
   // ---------------------------------------------------------------------
   assign acc_new_value = req_memory_value + (req_func[3] ? BYTE_ONES : 8'h01);

   always_comb begin
      index_x_in = index_x_ff;
      index_y_in = index_y_ff;
      pc_in      = pc_ff;
      flag_z_in  = flag_z_ff;
      flag_n_in  = flag_n_ff;
      if (req_real) begin
         case (req_func) inside
            FUNC_INX: begin
               index_x_in = index_x_ff + 8'h01;
               flag_z_in  = (index_x_in == 8'h00);
               flag_n_in  = index_x_in[7];
            end
            FUNC_INY: begin
               index_y_in = index_y_ff + 8'h01;
               flag_z_in  = (index_y_in == 8'h00);
               flag_n_in  = index_y_in[7];
            end
            FUNC_DEX: begin
               index_x_in = index_x_ff + BYTE_ONES;
               flag_z_in  = (index_x_in == 8'h00);
               flag_n_in  = index_x_in[7];
            end
            FUNC_DEY: begin
               index_y_in = index_y_ff + BYTE_ONES;
               flag_z_in  = (index_y_in == 8'h00);
               flag_n_in  = index_y_in[7];
            end
            FUNC_LOAD_PC: begin
               pc_in = {req_operand_high, req_operand_low};
            end
            FUNC_LOAD_XY: begin
               index_x_in = req_operand_low;
               index_y_in = req_operand_high;
            end
            default: begin
               // memory forms: one or two operand fetches advance pc
               pc_in     = pc_ff + (req_func[1] ? 16'd2 : 16'd1);
               flag_z_in = (acc_new_value == 8'h00);
               flag_n_in = acc_new_value[7];
            end
         endcase
      end
   end

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      beat_in      = beat_ff;
      if (issue) begin
         beat_in = beat_ff + beat_type'(1);
         if (beat_last) begin
            job_valid_in = 1'b0;
         end
      end
      if (req_take) begin
         job_valid_in = req_real;
         beat_in      = beat_type'(0);
      end
      if (req_real) begin
         job_in.func      = req_func;
         job_in.lo        = req_operand_low;
         job_in.hi        = req_operand_high;
         job_in.mem       = req_memory_value;
         job_in.new_value = acc_new_value;
         job_in.pc        = pc_ff;
         job_in.x_old     = index_x_ff;
         job_in.new_x     = index_x_in;
         job_in.new_y     = index_y_in;
         job_in.new_z     = flag_z_in;
         job_in.new_n     = flag_n_in;
      end
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_n_in     = rsp_n_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = beat_addr;
         rsp_data_in  = beat_data;
         rsp_kind_in  = beat_kind;
         rsp_last_in  = beat_last;
         rsp_z_in     = job_ff.new_z;
         rsp_n_in     = job_ff.new_n;
         rsp_x_in     = job_ff.new_x;
         rsp_y_in     = job_ff.new_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_x_ff   <= 8'h00;
         index_y_ff   <= 8'h00;
         pc_ff        <= 16'h0000;
         flag_z_ff    <= 1'b0;
         flag_n_ff    <= 1'b0;
         job_valid_ff <= 1'b0;
         beat_ff      <= beat_type'(0);
         rsp_valid_ff <= 1'b0;
      end else begin
         index_x_ff   <= index_x_in;
         index_y_ff   <= index_y_in;
         pc_ff        <= pc_in;
         flag_z_ff    <= flag_z_in;
         flag_n_ff    <= flag_n_in;
         job_valid_ff <= job_valid_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_n_ff    <= rsp_n_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bus_address   = rsp_addr_ff;
   assign rsp_bus_data      = rsp_data_ff;
   assign rsp_bus_kind      = rsp_kind_ff;
   assign rsp_last_cycle    = rsp_last_ff;
   assign rsp_zero_flag     = rsp_z_ff;
   assign rsp_negative_flag = rsp_n_ff;
   assign rsp_index_x_out   = rsp_x_ff;
   assign rsp_index_y_out   = rsp_y_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // the beat counter never runs past the instruction's bus cycles
   `IDU_ASSERT_NOW(a_beat_in_range, clock, reset, job_valid_ff, beat_ff < total_beats)
   // a taken instruction starts sequencing at its first beat
   `IDU_ASSERT_NEXT(a_job_starts, clock, reset, req_real, job_valid_ff && (beat_ff == 3'd0))
   // the last beat frees the slot unless a new instruction came in
   `IDU_ASSERT_NEXT(a_job_retires, clock, reset, issue_last && !req_real, !job_valid_ff)
   // the beat moved out always carries the current instruction's last flag
   `IDU_ASSERT_NEXT(a_last_marked, clock, reset, issue, rsp_valid && (rsp_last_cycle == $past(beat_last)))

endmodule

FILE: tb/sv/tb_index_and_memory_inc_dec_unit.sv
`timescale 1ns / 100ps

import idu_pkg::*;

// one bus cycle as seen on the rsp channel
typedef struct packed {
   logic [15:0] address;
   logic [7:0]  data;
   kind_type    kind;
   logic        last;
   logic        zero;
   logic        negative;
   logic [7:0]  x;
   logic [7:0]  y;
} bus_cycle_type;

// shadow cpu state plus the queue of bus cycles still owed by the unit
class inc_dec_ledger;
   logic [7:0]    shadow_x;
   logic [7:0]    shadow_y;
   logic [15:0]   shadow_pc;
   logic          shadow_z;
   logic          shadow_n;
   bus_cycle_type bus_cycles_due[$];
   bus_cycle_type instr_cycles[$];
   int unsigned   error_count;

   function new();
      shadow_x = '0;
      shadow_y = '0;
      shadow_pc = '0;
      shadow_z = 1'b0;
      shadow_n = 1'b0;
      error_count = 0;
   endfunction

   function int unsigned pending();
      return bus_cycles_due.size();
   endfunction

   function void add_cycle(logic [15:0] address, logic [7:0] data, kind_type kind);
      bus_cycle_type c;
      c = '0;
      c.address = address;
      c.data = data;
      c.kind = kind;
      instr_cycles.push_back(c);
   endfunction

   function void set_flags(logic [7:0] v);
      shadow_z = (v == 8'h00);
      shadow_n = v[7];
   endfunction

   // advance the shadow cpu by one accepted instruction and queue its bus cycles
   function void run_instruction(func_type f, logic [7:0] lo, logic [7:0] hi,
                                 logic [7:0] mem);
      logic [1:0]  mode;
      logic        is_dec;
      logic [7:0]  low_sum;
      logic [15:0] target;
      logic [7:0]  new_value;
      bus_cycle_type c;
      instr_cycles.delete();
      if (f > FUNC_LOAD_XY) begin
         return;
      end
      case (f)
         FUNC_INX, FUNC_INY, FUNC_DEX, FUNC_DEY: begin
            add_cycle(shadow_pc, 8'h00, KIND_READ);
            case (f)
               FUNC_INX: begin
                  shadow_x = shadow_x + 8'd1;
                  set_flags(shadow_x);
               end
               FUNC_INY: begin
                  shadow_y = shadow_y + 8'd1;
                  set_flags(shadow_y);
               end
               FUNC_DEX: begin
                  shadow_x = shadow_x - 8'd1;
                  set_flags(shadow_x);
               end
               default: begin
                  shadow_y = shadow_y - 8'd1;
                  set_flags(shadow_y);
               end
            endcase
         end
         FUNC_LOAD_PC: begin
            shadow_pc = {hi, lo};
            add_cycle(16'h0000, 8'h00, KIND_NONE);
         end
         FUNC_LOAD_XY: begin
            shadow_x = lo;
            shadow_y = hi;
            add_cycle(16'h0000, 8'h00, KIND_NONE);
         end
         default: begin
            mode = 2'(f - FUNC_INC_ZP);
            is_dec = (f >= FUNC_DEC_ZP);
            low_sum = lo + shadow_x;
            add_cycle(shadow_pc, lo, KIND_READ);
            shadow_pc = shadow_pc + 16'd1;
            case (mode)
               MODE_ZP: begin
                  target = {8'h00, lo};
               end
               MODE_ZPX: begin
                  add_cycle({8'h00, lo}, 8'h00, KIND_READ);
                  target = {8'h00, low_sum};
               end
               default: begin
                  add_cycle(shadow_pc, hi, KIND_READ);
                  shadow_pc = shadow_pc + 16'd1;
                  target = {hi, lo};
                  if (mode == MODE_ABX) begin
                     add_cycle({hi, low_sum}, 8'h00, KIND_READ);
                     target = target + {8'h00, shadow_x};
                  end
               end
            endcase
            add_cycle(target, mem, KIND_READ);
            add_cycle(target, mem, KIND_WRITE);
            new_value = is_dec ? mem + BYTE_ONES : mem + 8'd1;
            set_flags(new_value);
            add_cycle(target, new_value, KIND_WRITE);
         end
      endcase
      foreach (instr_cycles[i]) begin
         c = instr_cycles[i];
         c.last = (i == instr_cycles.size() - 1);
         c.zero = shadow_z;
         c.negative = shadow_n;
         c.x = shadow_x;
         c.y = shadow_y;
         bus_cycles_due.push_back(c);
      end
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // compare one accepted rsp beat against the oldest owed bus cycle
   function void match_cycle(bus_cycle_type got);
      bus_cycle_type want;
      if (bus_cycles_due.size() == 0) begin
         $error("rsp beat with nothing outstanding: address %0h kind %0d",
                got.address, got.kind);
         error_count++;
         return;
      end
      want = bus_cycles_due.pop_front();
      compare_field("bus_address", want.address, got.address);
      compare_field("bus_data", 16'(want.data), 16'(got.data));
      compare_field("bus_kind", 16'(want.kind), 16'(got.kind));
      compare_field("last_cycle", 16'(want.last), 16'(got.last));
      compare_field("zero_flag", 16'(want.zero), 16'(got.zero));
      compare_field("negative_flag", 16'(want.negative), 16'(got.negative));
      compare_field("index_x_out", 16'(want.x), 16'(got.x));
      compare_field("index_y_out", 16'(want.y), 16'(got.y));
   endfunction
endclass

module tb_index_and_memory_inc_dec_unit;

   // func codes the unit swallows without any bus cycle
   localparam func_type FUNC_SPARE_LO = 4'd14;
   localparam func_type FUNC_SPARE_HI = 4'd15;
   localparam int unsigned RANDOM_ITEMS = 260;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   func_type    req_func = FUNC_INX;
   logic [7:0]  req_operand_low = 8'h00;
   logic [7:0]  req_operand_high = 8'h00;
   logic [7:0]  req_memory_value = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_bus_address;
   logic [7:0]  rsp_bus_data;
   kind_type    rsp_bus_kind;
   logic        rsp_last_cycle;
   logic        rsp_zero_flag;
   logic        rsp_negative_flag;
   logic [7:0]  rsp_index_x_out;
   logic [7:0]  rsp_index_y_out;

   // when set, both sides run back to back with no idle cycles
   bit calm = 1'b0;

   inc_dec_ledger ledger = new();

   index_and_memory_inc_dec_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_operand_low   (req_operand_low),
      .req_operand_high  (req_operand_high),
      .req_memory_value  (req_memory_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bus_address   (rsp_bus_address),
      .rsp_bus_data      (rsp_bus_data),
      .rsp_bus_kind      (rsp_bus_kind),
      .rsp_last_cycle    (rsp_last_cycle),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_negative_flag (rsp_negative_flag),
      .rsp_index_x_out   (rsp_index_x_out),
      .rsp_index_y_out   (rsp_index_y_out)
   );

   // 8 ns clock, starts low so the first rising edge comes after reset is set
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // bytes biased toward the values that flip z and n or wrap an address
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h7F;
         3: return 8'h80;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // present one req beat after a random gap and hold it until taken
   task automatic send_request(func_type f, logic [7:0] lo, logic [7:0] hi,
                               logic [7:0] mem);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_operand_low <= lo;
      req_operand_high <= hi;
      req_memory_value <= mem;
      // values read right after the edge are the ones the unit saw at it
      do @(posedge clock); while (!req_ready);
      ledger.run_instruction(f, lo, hi, mem);
   endtask

   // hold off new instructions until every owed bus cycle is out
   task automatic drain_unit();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.pending() != 0);
   endtask

   // rsp side: random back pressure per beat, every taken beat is checked
   initial begin
      int unsigned stall;
      bus_cycle_type seen;
      do @(posedge clock); while (reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         seen.address = rsp_bus_address;
         seen.data = rsp_bus_data;
         seen.kind = rsp_bus_kind;
         seen.last = rsp_last_cycle;
         seen.zero = rsp_zero_flag;
         seen.negative = rsp_negative_flag;
         seen.x = rsp_index_x_out;
         seen.y = rsp_index_y_out;
         ledger.match_cycle(seen);
      end
   end

   // req side: directed corners first, then random instructions
   initial begin
      int unsigned counted;
      bit drained;
      func_type f;
      counted = 0;
      drained = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register forms across the 8-bit wrap, z and n both ways
      send_request(FUNC_LOAD_XY, 8'hFF, 8'h00, 8'h00);
      send_request(FUNC_INX, 8'h00, 8'h00, 8'h00);
      send_request(FUNC_DEX, 8'hFF, 8'hFF, 8'hFF);
      send_request(FUNC_INY, 8'h00, 8'h00, 8'h00);
      send_request(FUNC_DEY, 8'h00, 8'h00, 8'h00);
      send_request(FUNC_DEY, 8'h00, 8'h00, 8'h00);
      // operand fetches straddle the top of memory, pc wraps to zero
      send_request(FUNC_LOAD_PC, 8'hFE, 8'hFF, 8'h00);
      send_request(FUNC_INC_ABS, 8'h34, 8'h12, 8'hFF);
      send_request(FUNC_DEC_ZP, 8'h00, 8'hFF, 8'h00);
      // zero page x wraps inside page zero
      send_request(FUNC_LOAD_XY, 8'h20, 8'h80, 8'h00);
      send_request(FUNC_INC_ZPX, 8'hF0, 8'h00, 8'h7F);
      send_request(FUNC_DEC_ZPX, 8'hFF, 8'h00, 8'h80);
      // absolute x: dummy read before the carry, then the 16-bit wrap
      send_request(FUNC_INC_ABX, 8'hF0, 8'h12, 8'h01);
      send_request(FUNC_DEC_ABX, 8'hF0, 8'hFF, 8'h01);
      send_request(FUNC_INC_ABX, 8'h00, 8'h00, 8'hFE);
      send_request(FUNC_INC_ZP, 8'hFF, 8'hFF, 8'h00);
      send_request(FUNC_DEC_ABS, 8'hFF, 8'hFF, 8'hFF);
      // spare codes produce nothing and change nothing
      send_request(FUNC_SPARE_LO, 8'hFF, 8'hFF, 8'hFF);
      send_request(FUNC_SPARE_HI, 8'h55, 8'hAA, 8'h55);
      // single fetch at the top of memory
      send_request(FUNC_LOAD_PC, 8'hFF, 8'hFF, 8'h00);
      send_request(FUNC_INC_ZP, 8'h55, 8'hAA, 8'hAA);
      send_request(FUNC_LOAD_XY, 8'h00, 8'hFF, 8'h00);
      send_request(FUNC_INC_ZPX, 8'h80, 8'h00, 8'h00);

      // let the unit empty completely once before the random run
      drain_unit();

      while (counted < RANDOM_ITEMS) begin
         // every third stretch of 40 runs with no idling on either side
         calm = ((counted / 40) % 3) == 2;
         if (!drained && counted >= RANDOM_ITEMS / 2) begin
            drain_unit();
            drained = 1'b1;
         end
         if ($urandom_range(0, 19) == 0) begin
            f = func_type'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
         end else begin
            f = func_type'($urandom_range(FUNC_INX, FUNC_LOAD_XY));
            counted++;
         end
         send_request(f, pick_byte(), pick_byte(), pick_byte());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // wait for the last bus cycles, then watch a while for strays
      do @(posedge clock); while (ledger.pending() != 0);
      repeat (24) @(posedge clock);
      if (ledger.error_count == 0) begin
         $display("tb_index_and_memory_inc_dec_unit: clean");
      end else begin
         $display("tb_index_and_memory_inc_dec_unit: errors");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #2000000;
      $display("tb_index_and_memory_inc_dec_unit: errors");
      $finish;
   end

endmodule
